[src/rfbm_pkg.sv]
package rfbm_pkg;

  localparam int PERIOD_W = 16;
  localparam int LEVEL_W  = 10;
  localparam int NCH      = 3;
  localparam int CH_W     = $clog2(NCH);

  localparam logic [CH_W-1:0] CH_RED   = CH_W'(0);
  localparam logic [CH_W-1:0] CH_GREEN = CH_W'(1);
  localparam logic [CH_W-1:0] CH_BLUE  = CH_W'(2);

  // full-scale level; widths are level * period / LEVEL_MAX
  localparam int LEVEL_MAX = 1000;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LEVEL_MAX);
  localparam logic [LEVEL_W-1:0] SPEED_MIN = LEVEL_W'(1);

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(22726);
  localparam logic [PERIOD_W-1:0] RESET_WIDTH  = PERIOD_W'(83 * 22726 / 1000);

  // exact divide by LEVEL_MAX: q = (p * DIV_MULT) >> DIV_SHIFT for p < 2**PROD_W
  localparam int PROD_W    = LEVEL_W + PERIOD_W;
  localparam int DIV_SHIFT = PROD_W + $clog2(LEVEL_MAX);
  localparam logic [63:0] DIV_MULT =
      ((64'd1 << DIV_SHIFT) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX);
  localparam int MULT_W = $clog2(DIV_MULT + 64'd1);
  localparam int QFULL_W = PROD_W + MULT_W;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_BLUE  = 2'd2,
    MODE_GREEN = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PRESS   = 3'b010,
    PH_RELEASE = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    WH_RED_GREEN  = 3'b001,
    WH_GREEN_BLUE = 3'b010,
    WH_BLUE_RED   = 3'b100
  } wheel_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] speed;
    mode_t              mode;
    logic [NCH-1:0]     en;
  } status_t;

  typedef struct packed {
    status_t                        st;
    logic [NCH-1:0]                 wr;
    logic [NCH-1:0][LEVEL_W-1:0]    lvl;
  } req_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_out;
  } pipe_ctl_t;

endpackage

[src/rfbm_ctrl.sv]
module rfbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic              tick,
  input  logic              sw1,
  input  logic              sw2,
  output rfbm_pkg::req_t    req
);

  rfbm_pkg::phase_t ph1, ph1_next, ph2, ph2_next;
  rfbm_pkg::wheel_t wheel, wheel_next;
  rfbm_pkg::mode_t  mode, mode_next;
  logic             long1, long1_next, long2, long2_next;
  logic [1:0]       press_count, press_count_next;
  logic [rfbm_pkg::LEVEL_W-1:0] speed, speed_next;
  logic [rfbm_pkg::NCH-1:0]     en, en_next;
  logic [rfbm_pkg::NCH-1:0][rfbm_pkg::LEVEL_W-1:0] lvl, lvl_next;
  logic [rfbm_pkg::NCH-1:0]     wr;
  logic [rfbm_pkg::NCH-1:0][rfbm_pkg::LEVEL_W-1:0] lvl_out;
  logic [rfbm_pkg::CH_W-1:0]    sel;
  logic [rfbm_pkg::LEVEL_W:0]   sum;
  logic [rfbm_pkg::LEVEL_W-1:0] man;

  always_comb begin
    ph1_next = ph1;
    ph2_next = ph2;
    long1_next = long1;
    long2_next = long2;
    press_count_next = press_count;
    mode_next = mode;
    speed_next = speed;
    en_next = en;
    lvl_next = lvl;
    wheel_next = wheel;
    wr = '0;
    lvl_out = lvl;
    sel = rfbm_pkg::CH_GREEN;
    sum = '0;
    man = '0;

    if (!tick) begin
      case (ph1)
        rfbm_pkg::PH_IDLE: begin
          if (sw1) begin
            ph1_next = rfbm_pkg::PH_PRESS;
            if (long2 && press_count != 2'd3) press_count_next = press_count + 2'd1;
          end
        end
        rfbm_pkg::PH_PRESS: begin
          if (sw1) begin
            ph1_next = rfbm_pkg::PH_RELEASE;
            long1_next = 1'b1;
          end
        end
        rfbm_pkg::PH_RELEASE: begin
          if (!sw1) begin
            ph1_next = rfbm_pkg::PH_IDLE;
            long1_next = 1'b0;
          end
        end
        default: ph1_next = rfbm_pkg::PH_IDLE;
      endcase

      case (ph2)
        rfbm_pkg::PH_IDLE: begin
          if (sw2) ph2_next = rfbm_pkg::PH_PRESS;
        end
        rfbm_pkg::PH_PRESS: begin
          if (sw2) begin
            ph2_next = rfbm_pkg::PH_RELEASE;
            long2_next = 1'b1;
          end
        end
        rfbm_pkg::PH_RELEASE: begin
          if (press_count_next == 2'd1) begin
            mode_next = rfbm_pkg::MODE_RED;
            en_next = '0;
            en_next[rfbm_pkg::CH_RED] = 1'b1;
          end else if (press_count_next == 2'd2) begin
            mode_next = rfbm_pkg::MODE_BLUE;
            en_next = '0;
            en_next[rfbm_pkg::CH_BLUE] = 1'b1;
          end
          // a held SW1 wins over the press count
          if (long1_next) begin
            mode_next = rfbm_pkg::MODE_GREEN;
            en_next = '0;
            en_next[rfbm_pkg::CH_GREEN] = 1'b1;
          end
          if (!sw2) begin
            ph2_next = rfbm_pkg::PH_IDLE;
            long2_next = 1'b0;
            press_count_next = 2'd0;
          end
        end
        default: ph2_next = rfbm_pkg::PH_IDLE;
      endcase

      if (mode_next == rfbm_pkg::MODE_AUTO) begin
        if (ph1_next != rfbm_pkg::PH_IDLE) begin
          if (speed < rfbm_pkg::LEVEL_TOP) speed_next = speed + rfbm_pkg::LEVEL_W'(1);
        end else if (ph2_next != rfbm_pkg::PH_IDLE) begin
          if (speed > rfbm_pkg::SPEED_MIN) speed_next = speed - rfbm_pkg::LEVEL_W'(1);
        end
      end
    end else if (mode == rfbm_pkg::MODE_AUTO) begin
      // widths take the levels held before this wheel step
      wr = '1;
      case (wheel)
        rfbm_pkg::WH_RED_GREEN: begin
          en_next[rfbm_pkg::CH_BLUE] = 1'b0;
          en_next[rfbm_pkg::CH_GREEN] = 1'b1;
          lvl_next[rfbm_pkg::CH_RED] = (lvl[rfbm_pkg::CH_RED] < speed) ? '0 :
                                       lvl[rfbm_pkg::CH_RED] - speed;
          sum = {1'b0, lvl[rfbm_pkg::CH_GREEN]} + {1'b0, speed};
          if (sum > {1'b0, rfbm_pkg::LEVEL_TOP}) begin
            lvl_next[rfbm_pkg::CH_GREEN] = rfbm_pkg::LEVEL_TOP;
            wheel_next = rfbm_pkg::WH_GREEN_BLUE;
          end else begin
            lvl_next[rfbm_pkg::CH_GREEN] = sum[rfbm_pkg::LEVEL_W-1:0];
          end
          lvl_next[rfbm_pkg::CH_BLUE] = '0;
        end
        rfbm_pkg::WH_GREEN_BLUE: begin
          en_next[rfbm_pkg::CH_RED] = 1'b0;
          en_next[rfbm_pkg::CH_BLUE] = 1'b1;
          lvl_next[rfbm_pkg::CH_RED] = '0;
          lvl_next[rfbm_pkg::CH_GREEN] = (lvl[rfbm_pkg::CH_GREEN] < speed) ? '0 :
                                         lvl[rfbm_pkg::CH_GREEN] - speed;
          sum = {1'b0, lvl[rfbm_pkg::CH_BLUE]} + {1'b0, speed};
          if (sum > {1'b0, rfbm_pkg::LEVEL_TOP}) begin
            lvl_next[rfbm_pkg::CH_BLUE] = rfbm_pkg::LEVEL_TOP;
            wheel_next = rfbm_pkg::WH_BLUE_RED;
          end else begin
            lvl_next[rfbm_pkg::CH_BLUE] = sum[rfbm_pkg::LEVEL_W-1:0];
          end
        end
        default: begin
          en_next[rfbm_pkg::CH_RED] = 1'b1;
          en_next[rfbm_pkg::CH_GREEN] = 1'b0;
          lvl_next[rfbm_pkg::CH_GREEN] = '0;
          lvl_next[rfbm_pkg::CH_BLUE] = (lvl[rfbm_pkg::CH_BLUE] < speed) ? '0 :
                                        lvl[rfbm_pkg::CH_BLUE] - speed;
          sum = {1'b0, lvl[rfbm_pkg::CH_RED]} + {1'b0, speed};
          if (sum > {1'b0, rfbm_pkg::LEVEL_TOP}) begin
            lvl_next[rfbm_pkg::CH_RED] = rfbm_pkg::LEVEL_TOP;
            wheel_next = rfbm_pkg::WH_RED_GREEN;
          end else begin
            lvl_next[rfbm_pkg::CH_RED] = sum[rfbm_pkg::LEVEL_W-1:0];
          end
        end
      endcase
    end else begin
      case (mode)
        rfbm_pkg::MODE_RED:  sel = rfbm_pkg::CH_RED;
        rfbm_pkg::MODE_BLUE: sel = rfbm_pkg::CH_BLUE;
        default:             sel = rfbm_pkg::CH_GREEN;
      endcase
      man = lvl[sel];
      // both switches: step up, then down
      if (sw1 && man < rfbm_pkg::LEVEL_TOP) man = man + rfbm_pkg::LEVEL_W'(1);
      if (sw2 && man != '0) man = man - rfbm_pkg::LEVEL_W'(1);
      lvl_next[sel] = man;
      wr[sel] = sw1 | sw2;
      lvl_out[sel] = man;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1 <= rfbm_pkg::PH_IDLE;
      ph2 <= rfbm_pkg::PH_IDLE;
      long1 <= 1'b0;
      long2 <= 1'b0;
      press_count <= 2'd0;
      speed <= rfbm_pkg::SPEED_MIN;
      mode <= rfbm_pkg::MODE_AUTO;
      // blue, green, red: red starts at full scale
      lvl <= {rfbm_pkg::LEVEL_W'(0), rfbm_pkg::LEVEL_W'(0), rfbm_pkg::LEVEL_TOP};
      wheel <= rfbm_pkg::WH_RED_GREEN;
      // blue off, green and red on
      en <= 3'b011;
    end else if (acc) begin
      ph1 <= ph1_next;
      ph2 <= ph2_next;
      long1 <= long1_next;
      long2 <= long2_next;
      press_count <= press_count_next;
      speed <= speed_next;
      mode <= mode_next;
      lvl <= lvl_next;
      wheel <= wheel_next;
      en <= en_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req.st.speed <= speed_next;
      req.st.mode <= mode_next;
      req.st.en <= en_next;
      req.wr <= wr;
      req.lvl <= lvl_out;
    end
  end

endmodule

[src/rfbm_scale.sv]
module rfbm_scale (
  input  logic                                        clk,
  input  logic                                        rst,
  input  rfbm_pkg::pipe_ctl_t                         ctl,
  input  rfbm_pkg::req_t                              req,
  input  logic [rfbm_pkg::PERIOD_W-1:0]               period,
  output rfbm_pkg::status_t                           st,
  output logic [rfbm_pkg::NCH-1:0][rfbm_pkg::PERIOD_W-1:0] width
);

  logic [rfbm_pkg::NCH-1:0][rfbm_pkg::PROD_W-1:0] prod;
  logic [rfbm_pkg::NCH-1:0]                       wr2;
  rfbm_pkg::status_t                              st2;
  logic [rfbm_pkg::NCH-1:0][rfbm_pkg::QFULL_W-1:0] qfull;

  // level * period
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int c = 0; c < rfbm_pkg::NCH; c++) begin
        prod[c] <= rfbm_pkg::PROD_W'(req.lvl[c]) * rfbm_pkg::PROD_W'(period);
      end
      wr2 <= req.wr;
      st2 <= req.st;
    end
  end

  // divide by the full-scale level through its reciprocal
  always_comb begin
    for (int c = 0; c < rfbm_pkg::NCH; c++) begin
      qfull[c] = rfbm_pkg::QFULL_W'(prod[c]) *
                 rfbm_pkg::QFULL_W'(rfbm_pkg::DIV_MULT[rfbm_pkg::MULT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < rfbm_pkg::NCH; c++) begin
        width[c] <= rfbm_pkg::RESET_WIDTH;
      end
    end else if (ctl.ld_out) begin
      for (int c = 0; c < rfbm_pkg::NCH; c++) begin
        if (wr2[c]) width[c] <= qfull[c][rfbm_pkg::DIV_SHIFT +: rfbm_pkg::PERIOD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) st <= st2;
  end

endmodule

[src/rgb_fade_button_mode_controller.sv]
// RGB fade controller with a two-button mode selector. Each input word is one
// tick: s_tuser low is a button-sample tick, high a fade/step tick; s_tdata
// carries the two switch levels. Sample ticks run a press/hold/release tracker
// per switch, count SW1 presses made under a held SW2 and pick manual red,
// blue or green (the block then stays manual), or in auto mode nudge the fade
// speed between 1 and 1000. Fade ticks turn the red-green-blue wheel in auto
// mode or step the chosen level by one in manual mode. Pulse widths are
// level * period / 1000, with the period taken from the cfg port (reset
// 22726); a new period only affects widths written after it. Every tick
// returns one output word with the enables, mode and speed after it; an
// auto fade tick writes widths from the levels held before its wheel step.
// Throughput is one word per cycle unless m_tready stalls the output; the
// tick logic, the level-times-period multiply and the reciprocal multiply
// that divides by 1000 each end in a register, the output register last.
// Write cfg only while no word is in flight.
module rgb_fade_button_mode_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] sw1_down, [1] sw2_down
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] red_width, [31:16] green_width, [47:32] blue_width, [48] red_enable,
  // [49] green_enable, [50] blue_enable, [52:51] light_mode, [62:53] fade_speed
  output logic [63:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // pulse_period_count
);

  logic                          acc;
  logic                          p1_valid, p2_valid, out_valid;
  logic                          p1_adv, p2_adv, out_adv;
  logic [rfbm_pkg::PERIOD_W-1:0] period;
  rfbm_pkg::req_t                req;
  rfbm_pkg::pipe_ctl_t           ctl;
  rfbm_pkg::status_t             st;
  logic [rfbm_pkg::NCH-1:0][rfbm_pkg::PERIOD_W-1:0] width;

  // each stage moves on when the one after it is empty or moving
  assign out_adv = !out_valid || m_tready;
  assign p2_adv  = !p2_valid || out_adv;
  assign p1_adv  = !p1_valid || p2_adv;

  assign s_tready = p1_adv;
  assign acc      = s_tvalid && p1_adv;
  assign cfg_ready = 1'b1;

  // ld_prod, ld_out
  assign ctl = {p1_valid && p2_adv, p2_valid && out_adv};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p1_adv) p1_valid <= s_tvalid;
      if (p2_adv) p2_valid <= p1_valid;
      if (out_adv) out_valid <= p2_valid;
    end
  end

  // period register; held widths keep their old scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= rfbm_pkg::RESET_PERIOD;
    end else if (cfg_valid) begin
      period <= cfg_data;
    end
  end

  rfbm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .tick (s_tuser),
    .sw1  (s_tdata[0]),
    .sw2  (s_tdata[1]),
    .req  (req)
  );

  rfbm_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req),
    .period (period),
    .st     (st),
    .width  (width)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, st.speed, st.mode,
                     st.en[rfbm_pkg::CH_BLUE], st.en[rfbm_pkg::CH_GREEN],
                     st.en[rfbm_pkg::CH_RED],
                     width[rfbm_pkg::CH_BLUE], width[rfbm_pkg::CH_GREEN],
                     width[rfbm_pkg::CH_RED]};

endmodule
